[design/assert_macros.svh]
// assertion macros used by activity_selection_counter
// no dependencies; empty bodies under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assert");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[design/asc_pkg.sv]
// types and constants for the activity selection counter
// no dependencies
package asc_pkg;
  localparam int MAX_ACTIVITIES = 1024;
  localparam int DAY_BITS = 16;
  localparam int ADDR_BITS = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
  localparam int CNT_BITS = $clog2(MAX_ACTIVITIES + 1);
  localparam int ENTRY_BITS = 2 * DAY_BITS;
  localparam logic [10:0] COUNT_MAX = 11'h7ff;

  typedef struct packed {
    logic [DAY_BITS-1:0] start_day;
    logic [DAY_BITS-1:0] end_day;
    logic                last;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] selected_count;
    logic        overflow;
  } out_beat_t;

  // ram port bundle
  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [ENTRY_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]  raddr;
  } ram_req_t;
endpackage

[design/asc_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module asc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[design/activity_selection_counter.sv]
// activity selection counter: loads activities, heap-sorts them in a ram, greedy scan
// load: one beat per cycle while in_ready is high. after the last beat: heapsort over n
// entries, each sift level reading root, left child and right child, then a greedy scan
// of the entries; result registered once any earlier result is taken, held until taken
// reset: synchronous active-low rst_n clears control, count and overflow; ram not cleared
// depends on asc_pkg, asc_ram, assert_macros.svh
`include "assert_macros.svh"
module activity_selection_counter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  asc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output asc_pkg::out_beat_t  out_data
);
  localparam int AB = asc_pkg::ADDR_BITS;
  localparam int CB = asc_pkg::CNT_BITS;
  localparam int EB = asc_pkg::ENTRY_BITS;
  localparam int DB = asc_pkg::DAY_BITS;

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_BUILD = 11'b00000000010,  // pick next sift root
    S_RDR   = 11'b00000000100,  // read root
    S_RDC1  = 11'b00000001000,  // read left child
    S_RDC2  = 11'b00000010000,  // read right child
    S_CMP   = 11'b00000100000,  // compare and swap
    S_EXT   = 11'b00001000000,  // swap top with end
    S_EXTW  = 11'b00010000000,
    S_SCAN  = 11'b00100000000,
    S_SCANW = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;       // stored count
  logic          ovf_r, ovf_nxt;
  logic [CB-1:0] len_r, len_nxt;       // heap length
  logic [CB-1:0] bi_r, bi_nxt;         // build index
  logic          bld_r, bld_nxt;       // building phase
  logic [CB:0]   root_r, root_nxt;
  logic [EB-1:0] rv_r, rv_nxt, c1_r, c1_nxt;
  logic [1:0]    sub_r, sub_nxt;       // read/write phase counter
  logic [CB-1:0] si_r, si_nxt;         // scan index
  logic [DB-1:0] run_r, run_nxt;
  logic [11:0]   taken_r, taken_nxt;
  logic          ov_r, ov_nxt;
  asc_pkg::out_beat_t od_r, od_nxt;
  asc_pkg::ram_req_t  req;
  logic [EB-1:0] rdata;

  // key: end day high, start day low
  function automatic logic [EB-1:0] key_of(logic [DB-1:0] s, logic [DB-1:0] e);
    return {e, s};
  endfunction

  asc_ram #(.WIDTH(EB), .DEPTH(asc_pkg::MAX_ACTIVITIES)) u_ram (
    .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wdata),
    .raddr(req.raddr), .rdata(rdata)
  );

  logic [CB:0] lc, rc;
  assign lc = {root_r[CB-1:0], 1'b1};
  assign rc = lc + 1'b1;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    logic [EB-1:0] big;
    logic [CB:0]   bigi;
    state_nxt = state_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; len_nxt = len_r;
    bi_nxt = bi_r; bld_nxt = bld_r; root_nxt = root_r; rv_nxt = rv_r; c1_nxt = c1_r;
    sub_nxt = sub_r; si_nxt = si_r; run_nxt = run_r; taken_nxt = taken_r;
    ov_nxt = ov_r; od_nxt = od_r;
    req = '0;
    big = '0; bigi = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CB'(asc_pkg::MAX_ACTIVITIES)) begin
            req.we = 1'b1;
            req.waddr = cnt_r[AB-1:0];
            req.wdata = key_of(in_data.start_day[DB-1:0], in_data.end_day[DB-1:0]);
            cnt_nxt = cnt_r + 1'b1;
          end else ovf_nxt = 1'b1;
          if (in_data.last) begin
            len_nxt = (cnt_r < CB'(asc_pkg::MAX_ACTIVITIES)) ? cnt_r + 1'b1 : cnt_r;
            bi_nxt = len_nxt >> 1;
            bld_nxt = 1'b1;
            state_nxt = S_BUILD;
          end
        end
      end
      S_BUILD: begin
        if (bld_r) begin
          if (bi_r == '0) begin
            bld_nxt = 1'b0;
            state_nxt = S_EXT;
          end else begin
            bi_nxt = bi_r - 1'b1;
            root_nxt = {1'b0, bi_r - 1'b1};
            state_nxt = S_RDR;
          end
        end else state_nxt = S_EXT;
        sub_nxt = '0;
      end
      S_RDR: begin
        // pipeline: root, left child, right child reads
        if (lc >= {1'b0, len_r}) state_nxt = S_BUILD;
        else begin
          req.raddr = root_r[AB-1:0];
          state_nxt = S_RDC1;
        end
      end
      S_RDC1: begin
        rv_nxt = rdata;  // root
        req.raddr = lc[AB-1:0];
        state_nxt = S_RDC2;
      end
      S_RDC2: begin
        c1_nxt = rdata;  // left child
        req.raddr = rc[AB-1:0];
        state_nxt = S_CMP;
        sub_nxt = '0;
      end
      S_CMP: begin
        if (sub_r == 2'd0) begin
          // rdata holds the right child here
          big = c1_r; bigi = lc;
          if (rc < {1'b0, len_r} && rdata > c1_r) begin
            big = rdata; bigi = rc;
          end
          if (rv_r >= big) state_nxt = S_BUILD;
          else begin
            req.we = 1'b1; req.waddr = root_r[AB-1:0]; req.wdata = big;
            root_nxt = bigi;
            sub_nxt = 2'd1;
          end
        end else begin
          // second write: old root to child
          req.we = 1'b1; req.waddr = root_r[AB-1:0]; req.wdata = rv_r;
          state_nxt = S_RDR;
          sub_nxt = 2'd0;
        end
      end
      S_EXT: begin
        if (len_r <= 1) begin
          si_nxt = '0; run_nxt = '0; taken_nxt = '0;
          req.raddr = '0;
          state_nxt = S_SCAN;
        end else begin
          if (sub_r == 2'd0) begin req.raddr = '0; sub_nxt = 2'd1; end
          else if (sub_r == 2'd1) begin
            req.raddr = AB'(len_r - 1'b1); sub_nxt = 2'd2;
          end else if (sub_r == 2'd2) begin
            c1_nxt = rdata; req.raddr = '0; sub_nxt = 2'd3;
          end else begin
            // rdata holds the top entry, c1_r the end entry
            req.we = 1'b1; req.waddr = AB'(len_r - 1'b1); req.wdata = rdata;
            rv_nxt = c1_r; state_nxt = S_EXTW;
          end
        end
      end
      S_EXTW: begin
        req.we = 1'b1; req.waddr = '0; req.wdata = rv_r;
        len_nxt = len_r - 1'b1;
        root_nxt = '0;
        sub_nxt = '0;
        state_nxt = S_RDR;
      end
      S_SCAN: begin
        req.raddr = si_r[AB-1:0];
        if (si_r == cnt_r) state_nxt = S_OUT;
        else state_nxt = S_SCANW;
      end
      S_SCANW: begin
        if (rdata[DB-1:0] > run_r) begin
          taken_nxt = taken_r + 1'b1;
          run_nxt = rdata[EB-1:DB];
        end
        si_nxt = si_r + 1'b1;
        req.raddr = AB'(si_r + 1'b1);
        state_nxt = S_SCAN;
      end
      S_OUT: begin
        // wait for the previous result beat to leave before replacing it
        if (!ov_r) begin
          od_nxt.selected_count = (taken_r > 12'(asc_pkg::COUNT_MAX)) ?
                                  asc_pkg::COUNT_MAX : taken_r[10:0];
          od_nxt.overflow = ovf_r;
          ov_nxt = 1'b1;
          cnt_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0; bld_r <= 1'b0;
      sub_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
      bld_r <= bld_nxt; sub_r <= sub_nxt;
    end
    len_r <= len_nxt; bi_r <= bi_nxt; root_r <= root_nxt; rv_r <= rv_nxt;
    c1_r <= c1_nxt; si_r <= si_nxt; run_r <= run_nxt; taken_r <= taken_nxt;
    od_r <= od_nxt;
  end

  // a held result keeps its payload
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // no input taken except while loading
  `ASSERT_IMPL(a_in_load, clk, rst_n, in_ready |-> state_r == S_LOAD)
endmodule
